// ----- hw/rtl/hpt_pkg.sv -----
// ----------------------------------------------------------------------------
// hpt_pkg
// Types and constants shared by the header parameter tokenizer.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int MAX_LEN_DEF = 4096;
  localparam int FIELD_W     = 13;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // register index carried in paddr[2]
  localparam logic REG_NUL_IS_END = 1'b0;

  typedef enum logic [5:0] {
    PH_SKIP = 6'b000001,
    PH_NAME = 6'b000010,
    PH_EQ   = 6'b000100,
    PH_QVAL = 6'b001000,
    PH_BVAL = 6'b010000,
    PH_JUNK = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               param_found;
    logic [FIELD_W-1:0] name_offset;
    logic [FIELD_W-1:0] name_length;
    logic               has_value;
    logic [FIELD_W-1:0] value_offset;
    logic [FIELD_W-1:0] value_length;
    logic               value_quoted;
    logic               end_of_header;
    logic               too_long;
  } out_item_t;

endpackage

// ----- hw/rtl/header_param_tokenizer.sv -----
// ----------------------------------------------------------------------------
// header_param_tokenizer
// Splits a header value, one byte per item, into ;-separated name=value
// parameters and reports offsets and lengths of each one.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid / in_ready       in_item  (in_item_t)
//   out       output     out_valid / out_ready     out_item (out_item_t)
//   cfg       input      psel / penable / pready   paddr, pwdata, prdata
//
// one byte is taken every cycle while in_ready is high; a result appears in the cycle after its byte
// the parse state updates in one pass; a single output register holds results
// in_ready drops only while a result waits in the output register
// synchronous reset returns the parse state, out_valid and nul_is_end to their defaults
// ----------------------------------------------------------------------------
module header_param_tokenizer
  import hpt_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v >= POS_MAX) ? POS_MAX : v + POS_W'(1);
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [POS_W-1:0] v);
    logic [POS_W+FIELD_W-1:0] ext;
    ext = {{FIELD_W{1'b0}}, v};
    return ext[FIELD_W-1:0];
  endfunction

  logic nul_is_end;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] name_offset, name_offset_next;
  logic [POS_W-1:0] name_length, name_length_next;
  logic [POS_W-1:0] value_offset, value_offset_next;
  logic [POS_W-1:0] value_length, value_length_next;
  logic             has_value, has_value_next;
  logic             quoted, quoted_next;
  logic             stopped, stopped_next;
  logic             overflow, overflow_next;

  logic       in_accept;
  logic       found;
  logic       emit;
  logic       blank;
  logic [7:0] c;
  logic       last;
  out_item_t  result;

  assign pready    = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign c         = in_item.data_byte;
  assign last      = in_item.last_byte;
  assign blank     = (c == CH_SP) || (c == CH_TAB);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      nul_is_end <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NUL_IS_END) begin
      nul_is_end <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_NUL_IS_END) ? {{(DATA_W-1){1'b0}}, nul_is_end}
                                               : '0;

  // parse step
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    name_offset_next   = name_offset;
    name_length_next   = name_length;
    value_offset_next  = value_offset;
    value_length_next  = value_length;
    has_value_next     = has_value;
    quoted_next        = quoted;
    stopped_next       = stopped;
    overflow_next      = overflow;
    found              = 1'b0;

    if (!stopped) begin
      if (nul_is_end && c == CH_NUL) begin
        found        = (phase != PH_SKIP);
        phase_next   = PH_SKIP;
        stopped_next = 1'b1;
      end else begin
        if (byte_position >= POS_MAX) begin
          overflow_next = 1'b1;
        end
        byte_position_next = sat_inc(byte_position);
        unique case (phase)
          PH_SKIP: begin
            if (!(c == CH_SEMI || blank)) begin
              name_offset_next  = byte_position;
              value_offset_next = '0;
              value_length_next = '0;
              quoted_next       = 1'b0;
              if (c == CH_EQ) begin
                name_length_next  = '0;
                has_value_next    = 1'b1;
                value_offset_next = sat_inc(byte_position);
                phase_next        = PH_EQ;
              end else begin
                name_length_next = POS_W'(1);
                has_value_next   = 1'b0;
                phase_next       = PH_NAME;
              end
            end
          end
          PH_NAME: begin
            if (c == CH_EQ) begin
              has_value_next    = 1'b1;
              value_offset_next = sat_inc(byte_position);
              value_length_next = '0;
              phase_next        = PH_EQ;
            end else if (c == CH_SEMI) begin
              found      = 1'b1;
              phase_next = PH_SKIP;
            end else if (blank) begin
              phase_next = PH_JUNK;
            end else begin
              name_length_next = sat_inc(name_length);
            end
          end
          PH_EQ: begin
            if (c == CH_QUOTE) begin
              quoted_next       = 1'b1;
              value_offset_next = sat_inc(byte_position);
              value_length_next = '0;
              phase_next        = PH_QVAL;
            end else begin
              value_offset_next = byte_position;
              if (c == CH_SEMI) begin
                value_length_next = '0;
                found             = 1'b1;
                phase_next        = PH_SKIP;
              end else if (blank) begin
                value_length_next = '0;
                phase_next        = PH_JUNK;
              end else begin
                value_length_next = POS_W'(1);
                phase_next        = PH_BVAL;
              end
            end
          end
          PH_QVAL: begin
            if (c == CH_QUOTE) begin
              phase_next = PH_JUNK;
            end else begin
              value_length_next = sat_inc(value_length);
            end
          end
          PH_BVAL: begin
            if (c == CH_SEMI) begin
              found      = 1'b1;
              phase_next = PH_SKIP;
            end else if (blank) begin
              phase_next = PH_JUNK;
            end else begin
              value_length_next = sat_inc(value_length);
            end
          end
          PH_JUNK: begin
            if (c == CH_SEMI) begin
              found      = 1'b1;
              phase_next = PH_SKIP;
            end
          end
          default: begin
            phase_next = PH_SKIP;
          end
        endcase
      end
    end

    if (last && !found) begin
      found = (phase_next != PH_SKIP);
    end
    emit = found || last;

    result.param_found   = found;
    result.name_offset   = found ? to_field(name_offset_next) : '0;
    result.name_length   = found ? to_field(name_length_next) : '0;
    result.has_value     = found && has_value_next;
    result.value_offset  = (found && has_value_next) ? to_field(value_offset_next) : '0;
    result.value_length  = (found && has_value_next) ? to_field(value_length_next) : '0;
    result.value_quoted  = found && has_value_next && quoted_next;
    result.end_of_header = last;
    result.too_long      = overflow_next;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst || (in_accept && last)) begin
      phase         <= PH_SKIP;
      byte_position <= '0;
      name_offset   <= '0;
      name_length   <= '0;
      value_offset  <= '0;
      value_length  <= '0;
      has_value     <= 1'b0;
      quoted        <= 1'b0;
      stopped       <= 1'b0;
      overflow      <= 1'b0;
    end else if (in_accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      name_offset   <= name_offset_next;
      name_length   <= name_length_next;
      value_offset  <= value_offset_next;
      value_length  <= value_length_next;
      has_value     <= has_value_next;
      quoted        <= quoted_next;
      stopped       <= stopped_next;
      overflow      <= overflow_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_item <= result;
    end
  end

  // checks
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.param_found |->
      out_item.name_length == '0 && !out_item.has_value && out_item.name_offset == '0)
    else $error("empty result carries parameter fields");

  a_no_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.has_value |->
      out_item.value_length == '0 && !out_item.value_quoted)
    else $error("value fields set without a value");

  a_stopped_skip: assert property (@(posedge clk) disable iff (rst)
    stopped |-> phase == PH_SKIP)
    else $error("parse continued after zero byte");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && last |=> byte_position == '0 && phase == PH_SKIP && !stopped && !overflow)
    else $error("state not cleared after final byte");

  a_last_reports: assert property (@(posedge clk) disable iff (rst)
    in_accept && last |=> out_valid && out_item.end_of_header)
    else $error("final byte gave no result");

endmodule
